// File: sv/bsrc_pkg.sv
// shared types, constants and pattern table for the six-step ramped commutator
`default_nettype none
package bsrc_pkg;

    localparam int PERIOD_BITS_DEF = 8;
    localparam int RAMP_BITS_DEF   = 16;

    localparam int CFG_PERIOD_W = 8;
    localparam int CFG_RAMP_W   = 16;
    localparam int PATTERN_W    = 6;
    localparam int STEP_W       = 4;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 24;

    localparam logic [1:0] REG_TARGET_PERIOD = 2'd0;
    localparam logic [1:0] REG_START_PERIOD  = 2'd1;
    localparam logic [1:0] REG_REVERSE_DIR   = 2'd2;
    localparam logic [1:0] REG_RAMP_INTERVAL = 2'd3;

    localparam logic [CFG_PERIOD_W-1:0] TARGET_PERIOD_RST = 8'd200;
    localparam logic [CFG_PERIOD_W-1:0] START_PERIOD_RST  = 8'd200;
    localparam logic [CFG_RAMP_W-1:0]   RAMP_INTERVAL_RST = 16'd800;

    localparam logic [STEP_W-1:0] LAST_STEP = 4'd11;
    localparam logic [STEP_W-1:0] HALF_SEQ  = 4'd6;

    typedef struct packed {
        logic                    at_target;
        logic [CFG_PERIOD_W-1:0] period_now;
        logic [STEP_W-1:0]       step_index;
        logic [PATTERN_W-1:0]    drive_pattern;
    } result_t;

    function automatic logic [PATTERN_W-1:0] step_pattern(input logic [STEP_W-1:0] k,
                                                          input logic rev);
        logic [PATTERN_W-1:0] p;
        p = '0;
        case (k)
            4'd0: p = rev ? 6'd33 : 6'd17;
            4'd1: p = rev ? 6'd34 : 6'd20;
            4'd2: p = rev ? 6'd10 : 6'd12;
            4'd3: p = rev ? 6'd12 : 6'd10;
            4'd4: p = rev ? 6'd20 : 6'd34;
            4'd5: p = rev ? 6'd17 : 6'd33;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// File: sv/bsrc_out_buf.sv
// two-entry output register with skid stage for the result channel
`default_nettype none
module bsrc_out_buf (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire bsrc_pkg::result_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output bsrc_pkg::result_t      out_data
);

    logic              main_valid_reg;
    logic              skid_valid_reg;
    bsrc_pkg::result_t main_data_reg;
    bsrc_pkg::result_t skid_data_reg;
    logic              push;
    logic              pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    assign push      = in_valid && in_ready;
    assign pop       = main_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                main_data_reg  <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= push;
                if (push) begin
                    main_data_reg <= in_data;
                end
            end
        end else if (push) begin
            if (!main_valid_reg) begin
                main_data_reg  <= in_data;
                main_valid_reg <= 1'b1;
            end else begin
                skid_data_reg  <= in_data;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held without main entry");

endmodule
`default_nettype wire

// File: sv/bldc_six_step_ramped_commutator.sv
// top level: six-step commutation sequencer with period ramp and apb configuration
//
// each request on the s_ channel is one time tick carrying hold and restart.
// every request gives exactly one result on the m_ channel: the drive
// pattern, the step index and period after the tick, and an at-target flag.
// the tick is computed combinationally from the state registers and written
// to an output register. one request is taken per cycle while s_tready is
// high; throughput is one tick per clock, as the state registers update
// on every accepted request.
// a skid stage behind the output register lets one more request in while
// a result waits; s_tready drops only when both are full, and nothing is
// lost or repeated under any stall pattern.
// synchronous active-low reset clears step, tick and ramp counters, loads
// the period with 200 and sets registers to their reset values.
// registers over apb at byte offsets 0x0 target period, 0x4 start period,
// 0x8 reverse direction, 0xc ramp interval; write them only while idle.
`default_nettype none
module bldc_six_step_ramped_commutator #(
    parameter int PERIOD_BITS = bsrc_pkg::PERIOD_BITS_DEF,
    parameter int RAMP_BITS   = bsrc_pkg::RAMP_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // hold, restart, zero fill
    input  wire logic [bsrc_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // drive_pattern[5:0], step_index[9:6], period_now[17:10], at_target[18], zero fill
    output logic [bsrc_pkg::M_TDATA_W-1:0]        m_tdata,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [bsrc_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [bsrc_pkg::PDATA_W-1:0]     pwdata,
    output logic [bsrc_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready
);

    localparam int CMP_W = (RAMP_BITS > bsrc_pkg::CFG_RAMP_W) ? RAMP_BITS
                                                               : bsrc_pkg::CFG_RAMP_W;

    logic [bsrc_pkg::CFG_PERIOD_W-1:0] target_period_reg;
    logic [bsrc_pkg::CFG_PERIOD_W-1:0] start_period_reg;
    logic                              reverse_dir_reg;
    logic [bsrc_pkg::CFG_RAMP_W-1:0]   ramp_interval_reg;

    logic [bsrc_pkg::STEP_W-1:0] step_pos_reg, step_pos_next;
    logic [PERIOD_BITS-1:0]      step_ticks_reg, step_ticks_next;
    logic [PERIOD_BITS-1:0]      cur_period_reg, cur_period_next;
    logic [RAMP_BITS-1:0]        ramp_ticks_reg, ramp_ticks_next;

    logic                        cfg_write;
    logic                        accept;
    logic                        hold;
    logic                        restart;
    logic [PERIOD_BITS-1:0]      tgt;
    logic [PERIOD_BITS-1:0]      start;
    logic [PERIOD_BITS-1:0]      period0;
    logic [PERIOD_BITS-1:0]      ticks1;
    logic [RAMP_BITS-1:0]        ramp1;
    logic                        advance;
    logic [bsrc_pkg::STEP_W-1:0] pat_idx;
    logic                        buf_ready;
    bsrc_pkg::result_t           result;
    bsrc_pkg::result_t           out_result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign s_tready  = buf_ready;
    assign accept    = s_tvalid && s_tready;
    assign hold      = s_tdata[0];
    assign restart   = s_tdata[1];
    assign tgt       = PERIOD_BITS'(target_period_reg);
    assign start     = PERIOD_BITS'(start_period_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_period_reg <= bsrc_pkg::TARGET_PERIOD_RST;
            start_period_reg  <= bsrc_pkg::START_PERIOD_RST;
            reverse_dir_reg   <= 1'b0;
            ramp_interval_reg <= bsrc_pkg::RAMP_INTERVAL_RST;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                bsrc_pkg::REG_TARGET_PERIOD:
                    target_period_reg <= pwdata[bsrc_pkg::CFG_PERIOD_W-1:0];
                bsrc_pkg::REG_START_PERIOD:
                    start_period_reg <= pwdata[bsrc_pkg::CFG_PERIOD_W-1:0];
                bsrc_pkg::REG_REVERSE_DIR:
                    reverse_dir_reg <= pwdata[0];
                bsrc_pkg::REG_RAMP_INTERVAL:
                    ramp_interval_reg <= pwdata[bsrc_pkg::CFG_RAMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            bsrc_pkg::REG_TARGET_PERIOD: prdata = bsrc_pkg::PDATA_W'(target_period_reg);
            bsrc_pkg::REG_START_PERIOD:  prdata = bsrc_pkg::PDATA_W'(start_period_reg);
            bsrc_pkg::REG_REVERSE_DIR:   prdata = bsrc_pkg::PDATA_W'(reverse_dir_reg);
            bsrc_pkg::REG_RAMP_INTERVAL: prdata = bsrc_pkg::PDATA_W'(ramp_interval_reg);
            default:                     prdata = '0;
        endcase
    end

    // one tick of the sequencer
    always_comb begin
        period0         = restart ? start : cur_period_reg;
        ramp1           = (ramp_ticks_reg == '1) ? ramp_ticks_reg : ramp_ticks_reg + 1'b1;
        ticks1          = step_ticks_reg + 1'b1;
        advance         = (ticks1 == '0) || (ticks1 >= period0);
        step_pos_next   = step_pos_reg;
        step_ticks_next = ticks1;
        cur_period_next = period0;
        ramp_ticks_next = ramp1;
        if (advance) begin
            step_ticks_next = '0;
            if (step_pos_reg >= bsrc_pkg::LAST_STEP) begin
                step_pos_next = '0;
                if ((CMP_W'(ramp1) > CMP_W'(ramp_interval_reg)) && (period0 != tgt)) begin
                    cur_period_next = (period0 < tgt) ? period0 + 1'b1 : period0 - 1'b1;
                    ramp_ticks_next = '0;
                end
            end else begin
                step_pos_next = step_pos_reg + 1'b1;
            end
        end
        if (hold) begin
            step_pos_next   = '0;
            step_ticks_next = '0;
            ramp_ticks_next = '0;
            cur_period_next = start;
        end
    end

    always_comb begin
        pat_idx = (step_pos_next >= bsrc_pkg::HALF_SEQ) ? step_pos_next - bsrc_pkg::HALF_SEQ
                                                         : step_pos_next;
        result.drive_pattern = hold ? '0 : bsrc_pkg::step_pattern(pat_idx, reverse_dir_reg);
        result.step_index    = step_pos_next;
        result.period_now    = bsrc_pkg::CFG_PERIOD_W'(cur_period_next);
        result.at_target     = (cur_period_next == tgt);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_pos_reg   <= '0;
            step_ticks_reg <= '0;
            cur_period_reg <= PERIOD_BITS'(bsrc_pkg::START_PERIOD_RST);
            ramp_ticks_reg <= '0;
        end else if (accept) begin
            step_pos_reg   <= step_pos_next;
            step_ticks_reg <= step_ticks_next;
            cur_period_reg <= cur_period_next;
            ramp_ticks_reg <= ramp_ticks_next;
        end
    end

    bsrc_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (buf_ready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = bsrc_pkg::M_TDATA_W'(out_result);

    assert property (@(posedge aclk) disable iff (!aresetn)
        step_pos_reg <= bsrc_pkg::LAST_STEP)
        else $error("step position out of sequence");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && hold) |=> (step_pos_reg == '0 && ramp_ticks_reg == '0 && m_tvalid))
        else $error("hold did not clear the sequence");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !hold && !restart) |=>
            (cur_period_reg == $past(cur_period_reg)
             || cur_period_reg == PERIOD_BITS'($past(cur_period_reg) + 1'b1)
             || cur_period_reg == PERIOD_BITS'($past(cur_period_reg) - 1'b1)))
        else $error("period moved by more than one tick");

endmodule
`default_nettype wire

// File: tb/bldc_six_step_ramped_commutator_test.sv
`timescale 1ns / 1ps
// testbench for the six-step ramped commutator: tick requests checked against a predicted state

module bldc_six_step_ramped_commutator_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SEQ_STEPS   = 12;
    localparam int RESULT_W    = $bits(bsrc_pkg::result_t);

    class commutation_scoreboard;
        logic [bsrc_pkg::CFG_PERIOD_W-1:0] target_period;
        logic [bsrc_pkg::CFG_PERIOD_W-1:0] start_period;
        logic                              reverse_dir;
        logic [bsrc_pkg::CFG_RAMP_W-1:0]   ramp_interval;
        logic [bsrc_pkg::STEP_W-1:0]       step_pos;
        logic [bsrc_pkg::CFG_PERIOD_W-1:0] step_ticks;
        logic [bsrc_pkg::CFG_PERIOD_W-1:0] cur_period;
        logic [bsrc_pkg::CFG_RAMP_W-1:0]   ramp_ticks;
        logic [bsrc_pkg::PATTERN_W-1:0]    fwd_order [6];
        logic [bsrc_pkg::PATTERN_W-1:0]    rev_order [6];
        bsrc_pkg::result_t                 expected_q [$];
        int errors, checked, n_holds, n_restarts, n_wraps, n_period_moves, n_at_target;

        function new();
            target_period = bsrc_pkg::TARGET_PERIOD_RST;
            start_period  = bsrc_pkg::START_PERIOD_RST;
            reverse_dir   = 1'b0;
            ramp_interval = bsrc_pkg::RAMP_INTERVAL_RST;
            step_pos      = '0;
            step_ticks    = '0;
            cur_period    = 8'd200;
            ramp_ticks    = '0;
            fwd_order     = '{6'd17, 6'd20, 6'd12, 6'd10, 6'd34, 6'd33};
            rev_order     = '{6'd33, 6'd34, 6'd10, 6'd12, 6'd20, 6'd17};
        endfunction

        function void write_reg(logic [1:0] idx, logic [bsrc_pkg::PDATA_W-1:0] value);
            case (idx)
                bsrc_pkg::REG_TARGET_PERIOD:
                    target_period = value[bsrc_pkg::CFG_PERIOD_W-1:0];
                bsrc_pkg::REG_START_PERIOD:
                    start_period  = value[bsrc_pkg::CFG_PERIOD_W-1:0];
                bsrc_pkg::REG_REVERSE_DIR:
                    reverse_dir   = value[0];
                bsrc_pkg::REG_RAMP_INTERVAL:
                    ramp_interval = value[bsrc_pkg::CFG_RAMP_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_tick(bit hold, bit restart);
            bsrc_pkg::result_t                 want;
            logic [bsrc_pkg::CFG_PERIOD_W-1:0] eff;
            if (hold) begin
                step_pos   = '0;
                step_ticks = '0;
                ramp_ticks = '0;
                cur_period = start_period;
                want.drive_pattern = '0;
                n_holds++;
            end else begin
                if (restart) begin
                    cur_period = start_period;
                    n_restarts++;
                end
                if (ramp_ticks != '1)
                    ramp_ticks++;
                eff = (cur_period == '0) ? 8'd1 : cur_period;
                step_ticks = step_ticks + 8'd1;
                if (step_ticks == '0 || step_ticks >= eff) begin
                    step_ticks = '0;
                    step_pos++;
                    if (step_pos >= SEQ_STEPS) begin
                        step_pos = '0;
                        n_wraps++;
                        if (ramp_ticks > ramp_interval && cur_period != target_period) begin
                            if (cur_period < target_period)
                                cur_period++;
                            else
                                cur_period--;
                            ramp_ticks = '0;
                            n_period_moves++;
                        end
                    end
                end
                want.drive_pattern = reverse_dir ? rev_order[step_pos % 6]
                                                 : fwd_order[step_pos % 6];
            end
            want.step_index = step_pos;
            want.period_now = cur_period;
            want.at_target  = (cur_period == target_period);
            if (want.at_target)
                n_at_target++;
            expected_q.push_back(want);
        endfunction

        function void compare_field(string name, int unsigned want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [bsrc_pkg::M_TDATA_W-1:0] data);
            bsrc_pkg::result_t got;
            bsrc_pkg::result_t want;
            got = bsrc_pkg::result_t'(data[RESULT_W-1:0]);
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with no request pending, expected none, actual %h",
                         $time, data);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("drive_pattern", want.drive_pattern, got.drive_pattern);
            compare_field("step_index", want.step_index, got.step_index);
            compare_field("period_now", want.period_now, got.period_now);
            compare_field("at_target", want.at_target, got.at_target);
        endfunction
    endclass

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [bsrc_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [bsrc_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [bsrc_pkg::PADDR_W-1:0]   paddr    = '0;
    logic [bsrc_pkg::PDATA_W-1:0]   pwdata   = '0;
    logic [bsrc_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    commutation_scoreboard sb = new();
    int sent   = 0;
    int cycles = 0;

    bldc_six_step_ramped_commutator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int sender_gap_pct();
        return (sent < 650) ? 26 : (sent < 1300) ? 64 : 0;
    endfunction

    function automatic int receiver_stall_pct();
        return (sent < 650) ? 64 : (sent < 1300) ? 26 : 0;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, sb.expected_q.size());
            $display("bldc_six_step_ramped_commutator test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        m_tready <= ($urandom_range(99) >= receiver_stall_pct());
    end

    task automatic send_tick(input bit hold, input bit restart);
        while ($urandom_range(99) < sender_gap_pct()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(bsrc_pkg::S_TDATA_W-2){1'b0}}, restart, hold};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_tick(hold, restart);
        sent++;
    endtask

    task automatic run_ticks(input int n, input int hold_pm, input int restart_pm);
        for (int i = 0; i < n; i++)
            send_tick($urandom_range(999) < hold_pm, $urandom_range(999) < restart_pm);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [bsrc_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge aclk);
    endtask

    task automatic set_config(input int target, input int start, input bit rev, input int ramp);
        wait_idle();
        write_reg(bsrc_pkg::REG_TARGET_PERIOD, target);
        write_reg(bsrc_pkg::REG_START_PERIOD, start);
        write_reg(bsrc_pkg::REG_REVERSE_DIR, bsrc_pkg::PDATA_W'(rev));
        write_reg(bsrc_pkg::REG_RAMP_INTERVAL, ramp);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, hold and restart combinations
        send_tick(0, 0);
        send_tick(0, 0);
        send_tick(0, 1);
        send_tick(1, 0);
        send_tick(1, 1);
        // shortest period, ramp check on every wrap
        set_config(41, 1, 1'b0, 0);
        send_tick(1, 0);
        for (int i = 0; i < 13; i++)
            send_tick(0, 0);
        send_tick(0, 1);
        // direction change in the middle of a sequence
        set_config(41, 1, 1'b1, 0);
        for (int i = 0; i < 4; i++)
            send_tick(0, 0);

        // ramp down to the lowest target
        set_config(41, 42, 1'b0, 0);
        send_tick(1, 0);
        run_ticks(600, 0, 0);

        // longest period, ramp never allowed
        set_config(250, 255, 1'b1, 65535);
        send_tick(1, 0);
        run_ticks(300, 2, 5);

        // short periods, direction flips, frequent hold and restart
        for (int i = 0; i < 4; i++) begin
            set_config((i % 2 == 0) ? 41 : $urandom_range(41, 250), $urandom_range(1, 8),
                       i[0], $urandom_range(0, 40));
            run_ticks(120, 25, 25);
        end

        // ramp up with an interval
        set_config(132, 3, 1'b0, 100);
        send_tick(0, 1);
        run_ticks(400, 1, 0);

        // heavy noise near the top target
        set_config(250, 255, 1'b1, 800);
        run_ticks(150, 300, 300);

        wait_idle();
        repeat (5) @(posedge aclk);
        $display("covered %0d ticks: %0d holds, %0d restarts, %0d sequence wraps",
                 sb.checked, sb.n_holds, sb.n_restarts, sb.n_wraps);
        $display("period moved %0d times, %0d ticks ended at target",
                 sb.n_period_moves, sb.n_at_target);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("bldc_six_step_ramped_commutator test passed");
        end else begin
            $display("bldc_six_step_ramped_commutator test failed");
        end
        $finish;
    end

endmodule
